>>> hdl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// Shared constants and codes for the instruction trace profiler.
// ----------------------------------------------------------------------------
package itp_pkg;

  // default sizes
  localparam int HIST_BINS_DEF     = 256;
  localparam int BRANCH_BINS_DEF   = 66;
  localparam int COUNTER_WIDTH_DEF = 32;

  // branch bucket code width (buckets 0..65)
  localparam int BUCKET_W = 7;

  // operations
  localparam logic [1:0] OP_RECORD = 2'd0;
  localparam logic [1:0] OP_FLUSH  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  // read table selects
  localparam logic [2:0] TS_UOPS   = 3'd0;
  localparam logic [2:0] TS_SIZE   = 3'd1;
  localparam logic [2:0] TS_BRANCH = 3'd2;
  localparam logic [2:0] TS_MIX    = 3'd3;
  localparam logic [2:0] TS_TOTALS = 3'd4;

  // totals bins
  localparam logic [7:0] TOT_MICRO = 8'd0;
  localparam logic [7:0] TOT_MACRO = 8'd1;
  localparam logic [7:0] TOT_PAIRS = 8'd2;

  // mix bins
  localparam int MIX_BINS = 5;
  localparam logic [2:0] MIX_LOAD   = 3'd0;
  localparam logic [2:0] MIX_STORE  = 3'd1;
  localparam logic [2:0] MIX_UNCOND = 3'd2;
  localparam logic [2:0] MIX_COND   = 3'd3;
  localparam logic [2:0] MIX_OTHER  = 3'd4;

  // memory access kinds
  localparam logic [1:0] MK_LOAD  = 2'd1;
  localparam logic [1:0] MK_STORE = 2'd2;

  // flag usage codes
  localparam logic [1:0] FL_UNUSED = 2'd0;
  localparam logic [1:0] FL_READ   = 2'd1;

endpackage

>>> hdl/itp_bucket.sv
// ----------------------------------------------------------------------------
// itp_bucket
// Two-stage log2 bucket of the absolute distance between two addresses.
// ----------------------------------------------------------------------------
module itp_bucket (
  input  logic                     clk,
  input  logic                     load,
  input  logic [63:0]              addr_a,
  input  logic [63:0]              addr_b,
  output logic [itp_pkg::BUCKET_W-1:0] bucket
);
  import itp_pkg::*;

  logic [63:0] dist_r;
  logic [7:0]  byte_r;
  logic [2:0]  byte_idx_r;
  logic [7:0]  byte_nxt;
  logic [2:0]  byte_idx_nxt;
  logic [2:0]  bit_idx;

  // stage 1: full 64-bit absolute difference
  always_ff @(posedge clk) begin
    if (load) begin
      dist_r <= (addr_a >= addr_b) ? (addr_a - addr_b) : (addr_b - addr_a);
    end
  end

  // highest nonzero byte
  always_comb begin
    byte_idx_nxt = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (dist_r[j*8 +: 8] != 8'd0) byte_idx_nxt = 3'(j);
    end
    byte_nxt = dist_r[{byte_idx_nxt, 3'b000} +: 8];
  end

  // stage 2: selected byte and its position
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    byte_idx_r <= byte_idx_nxt;
  end

  // leading one within the byte
  always_comb begin
    bit_idx = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (byte_r[k]) bit_idx = 3'(k);
    end
  end

  // zero distance goes to bucket 0
  assign bucket = (byte_r == 8'd0) ? '0
                : BUCKET_W'(2) + BUCKET_W'({byte_idx_r, bit_idx});

endmodule

>>> hdl/instruction_trace_profiler.sv
// ----------------------------------------------------------------------------
// instruction_trace_profiler
// Micro-op trace profiler: histograms in on-chip memories, mix and totals in
// registers, one counter returned per read item.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       input      in_valid/in_stall  operation, addresses, flags, select
//  out_      output     out_valid/out_stall count
//
//  record item: S_WR without a branch target, S_DIST, S_BKT and S_WR with one
//  (bucket unit plus branch memory read-modify-write); flush: S_WR.
//  read item: S_RESP, a cumulative branch read S_CUM then S_RESP (the branch
//  memory is swept from bucket 0 to the bin, one entry per cycle).
//  one item is in flight at a time; a read holds the block while out_stall
//  keeps the previous result in the output register.
//  after reset a clearing pass zeroes the memories with in_stall high.
// ----------------------------------------------------------------------------
module instruction_trace_profiler #(
  parameter int HIST_BINS     = itp_pkg::HIST_BINS_DEF,
  parameter int BRANCH_BINS   = itp_pkg::BRANCH_BINS_DEF,
  parameter int COUNTER_WIDTH = itp_pkg::COUNTER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_micro_op_index,
  input  logic [63:0] in_instr_addr,
  input  logic [63:0] in_fallthrough_addr,
  input  logic [63:0] in_target_addr,
  input  logic [1:0]  in_flag_use,
  input  logic [1:0]  in_mem_kind,
  input  logic [2:0]  in_table_select,
  input  logic [7:0]  in_bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_count
);
  import itp_pkg::*;

  localparam int HAW = $clog2(HIST_BINS);
  localparam int BAW = $clog2(BRANCH_BINS);
  localparam int CW  = COUNTER_WIDTH;
  localparam int CLR_N = (HIST_BINS > BRANCH_BINS) ? HIST_BINS : BRANCH_BINS;
  localparam int CLW = $clog2(CLR_N);
  localparam logic [63:0] CMAX = 64'((65'd1 << CW) - 65'd1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_DIST, S_BKT, S_WR, S_CUM, S_RESP} state_t;
  typedef enum logic [1:0] {RS_UOP, RS_SIZE, RS_REG} rsel_t;

  function automatic logic [HAW-1:0] clamp_bin(input logic [63:0] v);
    clamp_bin = (v > 64'(HIST_BINS - 1)) ? HAW'(HIST_BINS - 1) : v[HAW-1:0];
  endfunction

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    sat_inc = (c == {CW{1'b1}}) ? c : c + CW'(1);
  endfunction

  function automatic logic [63:0] sat_inc64(input logic [63:0] c);
    sat_inc64 = (c == '1) ? c : c + 64'd1;
  endfunction

  // memories
  logic [CW-1:0]  uop_mem  [HIST_BINS];
  logic [CW-1:0]  size_mem [HIST_BINS];
  logic [63:0]    br_mem   [BRANCH_BINS];

  logic [CW-1:0] uop_rd_r, size_rd_r;
  logic [63:0]   br_rd_r;

  // control and counters
  state_t        state_r;
  rsel_t         rsel_r;
  logic [CLW-1:0] clr_r;
  logic          upd_uop_r, upd_size_r, upd_br_r;
  logic [HAW-1:0] uop_waddr_r, size_waddr_r;
  logic [BAW-1:0] br_waddr_r, k_r, cum_end_r;
  logic [63:0]   acc_r, res_r;
  logic [63:0]   micro_total_r, macro_total_r;
  logic [CW-1:0] mix_r [MIX_BINS];
  logic [CW-1:0] pairs_r;
  logic [7:0]    last_uop_r;
  logic          last_read_r, seen_r;
  logic          out_valid_r;
  logic [63:0]   out_count_r;

  logic          accept, is_rec, is_flush, is_read, branch, first_uop;
  logic          bin_ok_hist, bin_ok_br;
  logic          clr_in_hist, clr_in_br;
  logic [HAW-1:0] last_bin, size_bin, uop_raddr, size_raddr;
  logic [BAW-1:0] br_raddr;
  logic          br_ren;
  logic [BUCKET_W-1:0] bucket;
  logic [2:0]    mix_idx;
  logic [63:0]   br_raw, cum_sum, resp_val;
  logic [CW-1:0] uop_cur, size_cur;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign is_rec    = (in_operation == OP_RECORD);
  assign is_flush  = (in_operation == OP_FLUSH);
  assign is_read   = (in_operation == OP_READ);
  assign branch    = (in_target_addr != 64'd0);
  assign first_uop = (in_micro_op_index == 8'd1);
  assign bin_ok_hist = ({1'b0, in_bin_index} < 9'(HIST_BINS));
  assign bin_ok_br   = ({1'b0, in_bin_index} < 9'(BRANCH_BINS));
  assign clr_in_hist = ({1'b0, clr_r} < (CLW+1)'(HIST_BINS));
  assign clr_in_br   = ({1'b0, clr_r} < (CLW+1)'(BRANCH_BINS));
  assign last_bin  = clamp_bin(64'(last_uop_r));
  assign size_bin  = clamp_bin(in_fallthrough_addr - in_instr_addr);
  assign uop_raddr  = is_read ? in_bin_index[HAW-1:0] : last_bin;
  assign size_raddr = is_read ? in_bin_index[HAW-1:0] : size_bin;

  // distance bucket unit
  itp_bucket u_bucket (
    .clk    (clk),
    .load   (accept),
    .addr_a (in_instr_addr),
    .addr_b (in_target_addr),
    .bucket (bucket)
  );

  // mix classification
  always_comb begin
    if (in_mem_kind == MK_LOAD)                    mix_idx = MIX_LOAD;
    else if (in_mem_kind == MK_STORE)              mix_idx = MIX_STORE;
    else if (branch && in_flag_use == FL_UNUSED)   mix_idx = MIX_UNCOND;
    else if (branch && in_flag_use == FL_READ)     mix_idx = MIX_COND;
    else                                           mix_idx = MIX_OTHER;
  end

  // branch memory read port address
  always_comb begin
    br_ren   = 1'b0;
    br_raddr = '0;
    case (state_r)
      S_IDLE: begin
        br_ren   = accept;
      end
      S_BKT: begin
        br_ren   = 1'b1;
        br_raddr = BAW'(bucket);
      end
      S_CUM: begin
        br_ren   = (k_r != cum_end_r);
        br_raddr = k_r + BAW'(1);
      end
      default: begin
        br_ren   = 1'b0;
      end
    endcase
  end

  // read data
  assign uop_cur  = uop_rd_r;
  assign size_cur = size_rd_r;
  assign br_raw   = br_rd_r;
  assign cum_sum  = acc_r + br_raw;

  always_comb begin
    case (rsel_r)
      RS_UOP:  resp_val = 64'(uop_cur);
      RS_SIZE: resp_val = 64'(size_cur);
      default: resp_val = res_r;
    endcase
  end

  // histogram memories: cleared after reset, read at accept, write back in S_WR
  always_ff @(posedge clk) begin
    if (accept) begin
      uop_rd_r  <= uop_mem[uop_raddr];
      size_rd_r <= size_mem[size_raddr];
    end
    if (state_r == S_CLR) begin
      if (clr_in_hist) begin
        uop_mem[clr_r[HAW-1:0]]  <= '0;
        size_mem[clr_r[HAW-1:0]] <= '0;
      end
    end else begin
      if (state_r == S_WR && upd_uop_r)  uop_mem[uop_waddr_r]   <= sat_inc(uop_cur);
      if (state_r == S_WR && upd_size_r) size_mem[size_waddr_r] <= sat_inc(size_cur);
    end
  end

  // branch memory holds raw per-bucket counts
  always_ff @(posedge clk) begin
    if (br_ren) br_rd_r <= br_mem[br_raddr];
    if (state_r == S_CLR) begin
      if (clr_in_br) br_mem[clr_r[BAW-1:0]] <= '0;
    end else if (state_r == S_WR && upd_br_r) begin
      br_mem[br_waddr_r] <= sat_inc64(br_raw);
    end
  end

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_r         <= '0;
      rsel_r        <= RS_REG;
      upd_uop_r     <= 1'b0;
      upd_size_r    <= 1'b0;
      upd_br_r      <= 1'b0;
      micro_total_r <= '0;
      macro_total_r <= '0;
      for (int m = 0; m < MIX_BINS; m++) mix_r[m] <= '0;
      pairs_r       <= '0;
      last_uop_r    <= '0;
      last_read_r   <= 1'b0;
      seen_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_RESP) out_valid_r <= 1'b0;
      case (state_r)
        S_CLR: begin
          // zero one entry of each memory per cycle while the index lies within its depth
          if (clr_r == CLW'(CLR_N - 1)) state_r <= S_IDLE;
          else clr_r <= clr_r + CLW'(1);
        end
        S_IDLE: begin
          if (accept) begin
            upd_uop_r    <= 1'b0;
            upd_size_r   <= 1'b0;
            upd_br_r     <= 1'b0;
            uop_waddr_r  <= last_bin;
            size_waddr_r <= size_bin;
            if (is_rec) begin
              micro_total_r <= sat_inc64(micro_total_r);
              if (first_uop) begin
                macro_total_r <= sat_inc64(macro_total_r);
                upd_uop_r     <= seen_r;
                upd_size_r    <= 1'b1;
              end
              upd_br_r         <= branch;
              mix_r[mix_idx]   <= sat_inc(mix_r[mix_idx]);
              if (last_read_r && branch) pairs_r <= sat_inc(pairs_r);
              last_uop_r  <= in_micro_op_index;
              last_read_r <= (in_flag_use == FL_READ);
              seen_r      <= 1'b1;
              state_r     <= branch ? S_DIST : S_WR;
            end else if (is_flush) begin
              upd_uop_r   <= seen_r;
              seen_r      <= 1'b0;
              last_uop_r  <= '0;
              last_read_r <= 1'b0;
              state_r     <= S_WR;
            end else if (is_read) begin
              rsel_r    <= RS_REG;
              res_r     <= '0;
              acc_r     <= '0;
              k_r       <= '0;
              cum_end_r <= in_bin_index[BAW-1:0];
              state_r   <= S_RESP;
              case (in_table_select)
                TS_UOPS: begin
                  if (bin_ok_hist) rsel_r <= RS_UOP;
                end
                TS_SIZE: begin
                  if (bin_ok_hist) rsel_r <= RS_SIZE;
                end
                TS_BRANCH: begin
                  if (bin_ok_br) state_r <= S_CUM;
                end
                TS_MIX: begin
                  if (in_bin_index < 8'(MIX_BINS)) res_r <= 64'(mix_r[in_bin_index[2:0]]);
                end
                TS_TOTALS: begin
                  if (in_bin_index == TOT_MICRO)      res_r <= micro_total_r;
                  else if (in_bin_index == TOT_MACRO) res_r <= macro_total_r;
                  else if (in_bin_index == TOT_PAIRS) res_r <= 64'(pairs_r);
                end
                default: begin
                  res_r <= '0;
                end
              endcase
            end
          end
        end
        S_DIST: begin
          state_r <= S_BKT;
        end
        S_BKT: begin
          br_waddr_r <= BAW'(bucket);
          state_r    <= S_WR;
        end
        S_WR: begin
          state_r <= S_IDLE;
        end
        S_CUM: begin
          // running sum of raw bucket counts up to the requested bin; zero if that bin is empty, capped at CMAX
          if (k_r == cum_end_r) begin
            res_r   <= (br_raw == 64'd0) ? 64'd0
                     : ((cum_sum > CMAX) ? CMAX : cum_sum);
            state_r <= S_RESP;
          end else begin
            acc_r <= cum_sum;
            k_r   <= k_r + BAW'(1);
          end
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_count_r <= resp_val;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

>>> tb/tb_instruction_trace_profiler.sv
// ----------------------------------------------------------------------------
// tb_instruction_trace_profiler
// Self-checking bench: a directed pass over the corner cases, then random
// macro-op traces mixed with flushes and counter reads. A local model of the
// profiler predicts every read, and each returned count is checked in order.
// ----------------------------------------------------------------------------
module tb_instruction_trace_profiler;
  timeunit 1ns;
  timeprecision 1ps;
  import itp_pkg::*;

  localparam int NBINS = HIST_BINS_DEF;
  localparam int NBKT  = BRANCH_BINS_DEF;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNTER_WIDTH_DEF) - 1;
  localparam longint unsigned ALL1 = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  uidx;
    logic [63:0] ia;
    logic [63:0] fa;
    logic [63:0] ta;
    logic [1:0]  fl;
    logic [1:0]  mk;
    logic [2:0]  tsel;
    logic [7:0]  bin;
  } trace_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = '0;
  logic [7:0]  in_micro_op_index = '0;
  logic [63:0] in_instr_addr = '0;
  logic [63:0] in_fallthrough_addr = '0;
  logic [63:0] in_target_addr = '0;
  logic [1:0]  in_flag_use = '0;
  logic [1:0]  in_mem_kind = '0;
  logic [2:0]  in_table_select = '0;
  logic [7:0]  in_bin_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_count;

  instruction_trace_profiler uut (.*);

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // profile state mirrored by the bench
  longint unsigned uops_hist [NBINS];
  longint unsigned size_hist [NBINS];
  longint unsigned bdist_hist [NBKT];
  longint unsigned bdist_cum [NBKT];
  longint unsigned mix_cnt [MIX_BINS];
  longint unsigned pair_cnt, micro_cnt, macro_cnt;
  logic [7:0] prev_uidx;
  bit prev_flag_read, in_macro;

  trace_item_t pending_items[$];
  longint unsigned expected_counts[$];
  int errors = 0;

  function automatic longint unsigned sat_inc(longint unsigned v);
    return (v < CNT_MAX) ? v + 1 : v;
  endfunction

  function automatic int clamp_bin(logic [63:0] v);
    return (v > NBINS - 1) ? NBINS - 1 : int'(v);
  endfunction

  function automatic int dist_bucket(logic [63:0] a, logic [63:0] b);
    logic [63:0] d;
    int msb;
    d = (a >= b) ? a - b : b - a;
    if (d == 0) return 0;
    msb = 0;
    for (int i = 0; i < 64; i++) if (d[i]) msb = i;
    return 2 + msb;
  endfunction

  // update the mirrored profile for one accepted item
  task automatic profile_item(trace_item_t it);
    bit br;
    int bk;
    longint unsigned v;
    br = (it.ta != 0);
    case (it.op)
      OP_RECORD: begin
        if (micro_cnt != ALL1) micro_cnt++;
        if (it.uidx == 8'd1) begin
          if (macro_cnt != ALL1) macro_cnt++;
          if (in_macro) uops_hist[prev_uidx] = sat_inc(uops_hist[prev_uidx]);
          size_hist[clamp_bin(it.fa - it.ia)] = sat_inc(size_hist[clamp_bin(it.fa - it.ia)]);
        end
        if (br) begin
          bk = dist_bucket(it.ia, it.ta);
          bdist_hist[bk] = sat_inc(bdist_hist[bk]);
          for (int j = bk; j < NBKT; j++) bdist_cum[j] = sat_inc(bdist_cum[j]);
        end
        if (it.mk == MK_LOAD) mix_cnt[MIX_LOAD] = sat_inc(mix_cnt[MIX_LOAD]);
        else if (it.mk == MK_STORE) mix_cnt[MIX_STORE] = sat_inc(mix_cnt[MIX_STORE]);
        else if (br && it.fl == FL_UNUSED) mix_cnt[MIX_UNCOND] = sat_inc(mix_cnt[MIX_UNCOND]);
        else if (br && it.fl == FL_READ) mix_cnt[MIX_COND] = sat_inc(mix_cnt[MIX_COND]);
        else mix_cnt[MIX_OTHER] = sat_inc(mix_cnt[MIX_OTHER]);
        if (prev_flag_read && br) pair_cnt = sat_inc(pair_cnt);
        prev_uidx = it.uidx;
        prev_flag_read = (it.fl == FL_READ);
        in_macro = 1'b1;
      end
      OP_FLUSH: begin
        if (in_macro) uops_hist[prev_uidx] = sat_inc(uops_hist[prev_uidx]);
        in_macro = 1'b0;
        prev_uidx = '0;
        prev_flag_read = 1'b0;
      end
      OP_READ: begin
        v = 0;
        case (it.tsel)
          TS_UOPS: v = uops_hist[it.bin];
          TS_SIZE: v = size_hist[it.bin];
          TS_BRANCH: if (it.bin < NBKT && bdist_hist[it.bin] != 0) v = bdist_cum[it.bin];
          TS_MIX: if (it.bin < MIX_BINS) v = mix_cnt[it.bin];
          TS_TOTALS: begin
            if (it.bin == TOT_MICRO) v = micro_cnt;
            else if (it.bin == TOT_MACRO) v = macro_cnt;
            else if (it.bin == TOT_PAIRS) v = pair_cnt;
          end
          default: v = 0;
        endcase
        expected_counts.push_back(v);
      end
      default: ;
    endcase
  endtask

  function automatic trace_item_t rec(logic [7:0] u, logic [63:0] ia, logic [63:0] fa,
                                      logic [63:0] ta, logic [1:0] fl, logic [1:0] mk);
    trace_item_t it;
    it.op = OP_RECORD; it.uidx = u; it.ia = ia; it.fa = fa; it.ta = ta;
    it.fl = fl; it.mk = mk;
    it.tsel = 3'($urandom); it.bin = 8'($urandom);
    return it;
  endfunction

  function automatic trace_item_t rd(logic [2:0] ts, logic [7:0] b);
    trace_item_t it;
    it = rec(8'($urandom), {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, 2'($urandom), 2'($urandom));
    it.op = OP_READ; it.tsel = ts; it.bin = b;
    return it;
  endfunction

  function automatic trace_item_t ctl(logic [1:0] op);
    trace_item_t it;
    it = rd(3'($urandom), 8'($urandom));
    it.op = op;
    return it;
  endfunction

  // random read, biased toward bins that can hold counts
  function automatic trace_item_t rand_read();
    logic [2:0] ts;
    logic [7:0] b;
    ts = 3'($urandom_range(0, 7));
    if (ts > TS_TOTALS && $urandom_range(0, 3) != 0) ts = 3'($urandom_range(0, 4));
    case (ts)
      TS_BRANCH: b = 8'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 255 : 65));
      TS_MIX:    b = 8'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 255 : 4));
      TS_TOTALS: b = 8'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 255 : 2));
      default:   b = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    endcase
    return rd(ts, b);
  endfunction

  // driver: bursts of items separated by random gaps
  trace_item_t cur_item;
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) profile_item(cur_item);
      if (in_valid && in_stall) begin
        // hold the stalled item
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        in_operation <= cur_item.op;
        in_micro_op_index <= cur_item.uidx;
        in_instr_addr <= cur_item.ia;
        in_fallthrough_addr <= cur_item.fa;
        in_target_addr <= cur_item.ta;
        in_flag_use <= cur_item.fl;
        in_mem_kind <= cur_item.mk;
        in_table_select <= cur_item.tsel;
        in_bin_index <= cur_item.bin;
        in_valid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: phases of no, light and heavy back-pressure
  int stall_phase = 0, phase_cycles = 0;
  always @(posedge clk) begin
    if (phase_cycles == 0) begin
      stall_phase = $urandom_range(0, 2);
      phase_cycles = $urandom_range(20, 150);
    end else begin
      phase_cycles--;
    end
    case (stall_phase)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // monitor: compare each count against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        $display("%0t: unexpected count, expected none, got %0d", $realtime, out_count);
        errors++;
      end else begin
        if (out_count !== expected_counts[0]) begin
          $display("%0t: count mismatch, expected %0d, got %0d", $realtime,
                   expected_counts[0], out_count);
          errors++;
        end
        void'(expected_counts.pop_front());
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic [63:0] pc, d, tgt;
    int nuops, sz;
    for (int i = 0; i < NBINS; i++) begin uops_hist[i] = 0; size_hist[i] = 0; end
    for (int i = 0; i < NBKT; i++) begin bdist_hist[i] = 0; bdist_cum[i] = 0; end
    for (int i = 0; i < MIX_BINS; i++) mix_cnt[i] = 0;
    pair_cnt = 0; micro_cnt = 0; macro_cnt = 0;
    prev_uidx = '0; prev_flag_read = 1'b0; in_macro = 1'b0;

    // directed: empty reads, empty flush, corner records, unused selectors
    pending_items.push_back(rd(TS_TOTALS, TOT_MICRO));
    pending_items.push_back(ctl(OP_FLUSH));
    pending_items.push_back(rd(TS_UOPS, 8'd0));
    pending_items.push_back(rec(8'd1, 64'h1000, 64'h1004, 64'h1000, FL_READ, 2'd0));
    pending_items.push_back(rec(8'd2, 64'h0, 64'h0, ALL1, FL_UNUSED, 2'd3));
    pending_items.push_back(rec(8'd255, ALL1, 64'h0, 64'h0, 2'd2, MK_LOAD));
    pending_items.push_back(rec(8'd1, 64'h10, 64'h1_0000_0000, 64'h8, 2'd3, MK_STORE));
    pending_items.push_back(rec(8'd0, 64'h2000, 64'h2002, 64'h2100, 2'd2, 2'd0));
    pending_items.push_back(ctl(2'd3));
    pending_items.push_back(ctl(OP_FLUSH));
    pending_items.push_back(rd(TS_UOPS, 8'd255));
    pending_items.push_back(rd(TS_UOPS, 8'd2));
    pending_items.push_back(rd(TS_SIZE, 8'd255));
    pending_items.push_back(rd(TS_SIZE, 8'd4));
    pending_items.push_back(rd(TS_BRANCH, 8'd0));
    pending_items.push_back(rd(TS_BRANCH, 8'd1));
    pending_items.push_back(rd(TS_BRANCH, 8'd65));
    pending_items.push_back(rd(TS_BRANCH, 8'd200));
    for (int i = 0; i < MIX_BINS; i++) pending_items.push_back(rd(TS_MIX, 8'(i)));
    pending_items.push_back(rd(TS_TOTALS, TOT_MACRO));
    pending_items.push_back(rd(TS_TOTALS, TOT_PAIRS));
    pending_items.push_back(rd(3'd7, 8'd0));

    // random: macro-op traces with reads, flushes and some noise
    pc = {$urandom, $urandom};
    while (pending_items.size() < 1220) begin
      case ($urandom_range(0, 19))
        0: pending_items.push_back(ctl(OP_FLUSH));
        1: pending_items.push_back(ctl(2'd3));
        2: pending_items.push_back(rec(8'($urandom), {$urandom, $urandom},
               {$urandom, $urandom}, {$urandom, $urandom}, 2'($urandom), 2'($urandom)));
        3, 4, 5, 6, 7: pending_items.push_back(rand_read());
        default: begin
          if ($urandom_range(0, 7) == 0) pc = {$urandom, $urandom};
          nuops = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 5);
          sz = ($urandom_range(0, 15) == 0) ? $urandom_range(256, 70000) : $urandom_range(1, 15);
          for (int u = 1; u <= nuops && u <= 6; u++) begin
            tgt = 64'h0;
            if ($urandom_range(0, 2) == 0) begin
              d = (64'd1 << $urandom_range(0, 63)) | {$urandom, $urandom} >> $urandom_range(0, 64);
              if ($urandom_range(0, 15) == 0) d = 0;
              tgt = $urandom_range(0, 1) ? pc + d : pc - d;
            end
            pending_items.push_back(rec((u == nuops || u == 6) && nuops > 6 ? 8'(nuops) : 8'(u),
                pc, pc + 64'(sz), tgt, 2'($urandom_range(0, 3)),
                ($urandom_range(0, 3) == 0) ? 2'(3) : 2'($urandom_range(0, 2))));
          end
          pc = pc + 64'(sz);
        end
      endcase
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_items.size() > 0 || in_valid) @(posedge clk);
    while (expected_counts.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_counts.size() == 0)
      $display("tb_instruction_trace_profiler: clean");
    else
      $display("tb_instruction_trace_profiler: errors");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("tb_instruction_trace_profiler: errors");
    $finish;
  end

endmodule
